// File: rtl/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TKSK_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("tksk assertion failed");
`define TKSK_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("tksk assertion failed");
`else
`define TKSK_ASSERT(lbl, clk, rstn, prop)
`define TKSK_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: rtl/tksk_pkg.sv
// types and constants of the top-k score keeper
`timescale 1ns / 1ps
package tksk_pkg;

    localparam int CAPACITY_DEF = 100;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    typedef struct packed {
        logic signed [31:0] profit;
        logic [15:0]        ratio;
        logic signed [47:0] score;
        logic [15:0]        fast;
        logic [15:0]        slow;
        logic [15:0]        candles;
    } t_rec;

    typedef struct packed {
        logic upd;
        logic full;
        t_rec rec;
    } t_bcast;

endpackage

// File: rtl/tksk_cell.sv
// one slot of the sorted record chain
`timescale 1ns / 1ps
module tksk_cell (
    input  logic            i_clk,
    input  tksk_pkg::t_bcast i_bcast,
    input  logic            i_valid,
    input  tksk_pkg::t_rec  i_prev_rec,
    input  logic            i_prev_le,
    input  tksk_pkg::t_rec  i_next_rec,
    input  logic            i_next_lt,
    output tksk_pkg::t_rec  o_rec,
    output logic            o_le,
    output logic            o_lt
);

    tksk_pkg::t_rec r_rec;
    tksk_pkg::t_rec n_rec;

    assign o_le  = i_valid && (r_rec.score <= i_bcast.rec.score);
    assign o_lt  = r_rec.score < i_bcast.rec.score;
    assign o_rec = r_rec;

    always_comb begin
        n_rec = r_rec;
        if (i_bcast.upd) begin
            if (!i_bcast.full) begin
                // append: shift up past the insertion point
                if (!o_le) begin
                    n_rec = i_prev_le ? i_bcast.rec : i_prev_rec;
                end
            end else begin
                // replace lowest: shift down below the insertion point
                if (i_next_lt) begin
                    n_rec = i_next_rec;
                end else if (o_lt) begin
                    n_rec = i_bcast.rec;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

endmodule

// File: rtl/top_k_score_keeper.sv
// top level of the top-k score keeper
//
// channel   direction  handshake             word
// command   in         start high, busy low  i_action .. i_candle_count
// result    out        o_valid strobe        o_accepted .. o_entry_candle_count
//
// the accept edge registers each word and the 32x16 score product,
// the next edge lets every cell compare against the new score and shift at once.
// the result strobe is registered at that same edge, while the next word may be taken.
// i_rst_n is synchronous and clears the control state and the fill count only.
// the receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module top_k_score_keeper #(
    parameter int CAPACITY = tksk_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_action,
    input  logic [6:0]         i_rank_index,
    input  logic signed [31:0] i_profit,
    input  logic [15:0]        i_ratio,
    input  logic [15:0]        i_fast_period,
    input  logic [15:0]        i_slow_period,
    input  logic [15:0]        i_candle_count,
    output logic               o_valid,
    output logic               o_accepted,
    output logic [6:0]         o_fill_count,
    output logic               o_entry_valid,
    output logic signed [31:0] o_entry_profit,
    output logic [15:0]        o_entry_ratio,
    output logic [15:0]        o_entry_fast_period,
    output logic [15:0]        o_entry_slow_period,
    output logic [15:0]        o_entry_candle_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RW = (CW > 7) ? CW : 7;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_UPD  = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    logic             r_action;
    logic [6:0]       r_rank;
    tksk_pkg::t_rec   r_rec;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;

    logic             r_out_valid;
    logic             r_out_accepted;
    logic [6:0]       r_out_fill;
    logic             r_out_entry_valid;
    tksk_pkg::t_rec   r_out_rec;

    logic signed [48:0] w_prod;
    logic               w_accept;
    logic               w_full;
    logic               w_ins_ok;
    logic               w_rd_valid;
    tksk_pkg::t_bcast   w_bcast;
    tksk_pkg::t_rec     w_sel;

    tksk_pkg::t_rec     w_rec [CAPACITY];
    logic [CAPACITY-1:0] w_le;
    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_vld;

    assign busy     = (r_state == S_UPD);
    assign w_accept = start && !busy;
    assign w_prod   = i_profit * $signed({1'b0, i_ratio});

    assign w_full   = (r_count == CW'(CAPACITY));
    assign w_ins_ok = !w_full || w_lt[0];

    assign w_bcast.upd  = busy && (r_action == tksk_pkg::ACT_INSERT) && w_ins_ok;
    assign w_bcast.full = w_full;
    assign w_bcast.rec  = r_rec;

    assign n_count = r_count + CW'(w_bcast.upd && !w_full);

    // cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        tksk_pkg::t_rec w_prev_rec;
        tksk_pkg::t_rec w_next_rec;
        logic           w_prev_le;
        logic           w_next_lt;

        assign w_vld[g] = (CW'(g) < r_count);

        if (g == 0) begin : g_head
            assign w_prev_rec = r_rec;
            assign w_prev_le  = 1'b1;
        end else begin : g_mid
            assign w_prev_rec = w_rec[g-1];
            assign w_prev_le  = w_le[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_next_rec = w_rec[g];
            assign w_next_lt  = 1'b0;
        end else begin : g_body
            assign w_next_rec = w_rec[g+1];
            assign w_next_lt  = w_lt[g+1];
        end

        tksk_cell u_cell (
            .i_clk      (i_clk),
            .i_bcast    (w_bcast),
            .i_valid    (w_vld[g]),
            .i_prev_rec (w_prev_rec),
            .i_prev_le  (w_prev_le),
            .i_next_rec (w_next_rec),
            .i_next_lt  (w_next_lt),
            .o_rec      (w_rec[g]),
            .o_le       (w_le[g]),
            .o_lt       (w_lt[g])
        );
    end

    // rank read
    assign w_rd_valid = (RW'(r_rank) < RW'(r_count));

    always_comb begin
        w_sel = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (RW'(k) == RW'(r_rank)) begin
                w_sel = w_rec[k];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action        <= i_action;
            r_rank          <= i_rank_index;
            r_rec.profit    <= i_profit;
            r_rec.ratio     <= i_ratio;
            r_rec.score     <= $signed(w_prod[47:0]);
            r_rec.fast      <= i_fast_period;
            r_rec.slow      <= i_slow_period;
            r_rec.candles   <= i_candle_count;
        end
        if (busy) begin
            r_out_accepted <= (r_action == tksk_pkg::ACT_INSERT) && w_ins_ok;
            r_out_fill     <= 7'(n_count);
            if ((r_action == tksk_pkg::ACT_READ) && w_rd_valid) begin
                r_out_entry_valid <= 1'b1;
                r_out_rec         <= w_sel;
            end else begin
                r_out_entry_valid <= 1'b0;
                r_out_rec         <= '0;
            end
        end
    end

    assign o_valid              = r_out_valid;
    assign o_accepted           = r_out_accepted;
    assign o_fill_count         = r_out_fill;
    assign o_entry_valid        = r_out_entry_valid;
    assign o_entry_profit       = r_out_rec.profit;
    assign o_entry_ratio        = r_out_rec.ratio;
    assign o_entry_fast_period  = r_out_rec.fast;
    assign o_entry_slow_period  = r_out_rec.slow;
    assign o_entry_candle_count = r_out_rec.candles;

    `TKSK_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(CAPACITY))
    `TKSK_ASSERT(a_busy_gives_result, i_clk, i_rst_n, busy |=> o_valid)
    `TKSK_ASSERT(a_count_only_on_update, i_clk, i_rst_n, !busy |=> $stable(r_count))
    `TKSK_ASSERT(a_read_never_accepts, i_clk, i_rst_n, (o_valid && o_accepted) |-> !o_entry_valid)
    `TKSK_ASSERT_ALWAYS(a_one_hot_state, i_clk, $onehot(r_state) || !i_rst_n || $isunknown(r_state))

endmodule
